// ===== design/wsdfr_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// Used by the parser, the result queue, the top level and the port checker.
package wsdfr_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam logic [31:0] MAX_LEN_RESET = 32'd1024;

    localparam int TDATA_W = 56;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_OP    = 3'd1;
    localparam logic [2:0] ST_UNMASKED  = 3'd2;
    localparam logic [2:0] ST_FRAG_CTRL = 3'd3;
    localparam logic [2:0] ST_TOO_BIG   = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;
    localparam logic [2:0] ST_CLOSE     = 3'd6;

    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PONG  = 4'hA;
    localparam logic [3:0] OP_FIRST_CTRL_RANGE = 4'h3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic        masked_flag;
        logic [31:0] payload_length;
        logic [2:0]  status;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ===== design/wsdfr_parser.sv =====
// Frame header parser, payload unmasking and status decision for one byte per beat.
// Depends on wsdfr_pkg; produces up to two result records per accepted byte.
module wsdfr_parser
    import wsdfr_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_fire,
    input  logic [7:0]  in_byte,
    input  logic        in_eob,
    output push_t       push
);

    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;
    localparam int CMP_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

    logic [31:0]            max_len_reg;
    logic [2:0]             phase_reg,  phase_next;
    logic [3:0]             hcnt_reg,   hcnt_next;
    logic                   fin_reg,    fin_next;
    logic [3:0]             op_reg,     op_next;
    logic                   mask_reg,   mask_next;
    logic [LENGTH_BITS-1:0] len_reg,    len_next;
    logic [31:0]            key_reg,    key_next;
    logic [1:0]             kpos_reg,   kpos_next;
    logic [LENGTH_BITS-1:0] rem_reg,    rem_next;

    logic                   hdr_done;
    logic                   pay_out;
    logic [7:0]             pay_byte;
    logic [7:0]             key_byte;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [CMP_W-1:0]       len_ext;
    logic [31:0]            len_clip;
    logic [2:0]             status_val;
    result_t                base, rec_a, rec_s;

    always_comb begin
        phase_next = phase_reg;
        hcnt_next  = hcnt_reg;
        fin_next   = fin_reg;
        op_next    = op_reg;
        mask_next  = mask_reg;
        len_next   = len_reg;
        key_next   = key_reg;
        kpos_next  = kpos_reg;
        rem_next   = rem_reg;
        hdr_done   = 1'b0;
        pay_out    = 1'b0;
        rem_dec    = rem_reg - LENGTH_BITS'(1);

        case (kpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        pay_byte = in_byte ^ key_byte;

        unique case (phase_reg)
            PH_FIRST: begin
                fin_next   = in_byte[7];
                op_next    = in_byte[3:0];
                phase_next = PH_SECOND;
            end
            PH_SECOND: begin
                mask_next = in_byte[7];
                len_next  = LENGTH_BITS'(in_byte[6:0]);
                hcnt_next = '0;
                rem_next  = '0;
                if (in_byte[6:0] == LEN7_EXT16) begin
                    phase_next = PH_EXT16;
                end else if (in_byte[6:0] == LEN7_EXT64) begin
                    phase_next = PH_EXT64;
                end else if (in_byte[7]) begin
                    phase_next = PH_KEY;
                end else begin
                    rem_next   = LENGTH_BITS'(in_byte[6:0]);
                    phase_next = (in_byte[6:0] != '0) ? PH_PAYLOAD : PH_DONE;
                    hdr_done   = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64: begin
                if (rem_reg[LENGTH_BITS-1 -: 8] != '0) begin
                    rem_next = '1;
                end else begin
                    rem_next = {rem_reg[LENGTH_BITS-9:0], in_byte};
                end
                hcnt_next = hcnt_reg + 4'd1;
                if (hcnt_next >= ((phase_reg == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
                    len_next  = rem_next;
                    hcnt_next = '0;
                    if (mask_reg) begin
                        phase_next = PH_KEY;
                    end else begin
                        phase_next = (rem_next != '0) ? PH_PAYLOAD : PH_DONE;
                        hdr_done   = 1'b1;
                    end
                end
            end
            PH_KEY: begin
                key_next  = {key_reg[23:0], in_byte};
                hcnt_next = hcnt_reg + 4'd1;
                if (hcnt_next >= KEY_BYTES) begin
                    hcnt_next  = '0;
                    kpos_next  = '0;
                    rem_next   = len_reg;
                    phase_next = (len_reg != '0) ? PH_PAYLOAD : PH_DONE;
                    hdr_done   = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                pay_out   = 1'b1;
                kpos_next = kpos_reg + 2'd1;
                rem_next  = rem_dec;
                if (rem_dec == '0) begin
                    phase_next = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        len_ext  = CMP_W'(len_next);
        len_clip = (len_ext > CMP_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : len_ext[31:0];

        if (op_next == OP_CLOSE) begin
            status_val = ST_CLOSE;
        end else if (op_next >= OP_FIRST_CTRL_RANGE && op_next != OP_PONG) begin
            status_val = ST_BAD_OP;
        end else if (!mask_next) begin
            status_val = ST_UNMASKED;
        end else if (!fin_next && op_next >= OP_CLOSE && op_next <= OP_PONG) begin
            status_val = ST_FRAG_CTRL;
        end else if (len_ext > CMP_W'(max_len_reg)) begin
            status_val = ST_TOO_BIG;
        end else if (phase_next != PH_DONE) begin
            status_val = ST_TRUNC;
        end else begin
            status_val = ST_OK;
        end

        base.kind           = KIND_PAYLOAD;
        base.data_byte      = '0;
        base.fin_flag       = fin_next;
        base.frame_opcode   = op_next;
        base.masked_flag    = mask_next;
        base.payload_length = len_clip;
        base.status         = ST_OK;
        base.last_of_run    = 1'b0;

        rec_a = base;
        if (pay_out) begin
            rec_a.data_byte = pay_byte;
        end else begin
            rec_a.kind = KIND_HEADER;
        end
        rec_a.last_of_run = !in_eob;

        rec_s             = base;
        rec_s.kind        = KIND_STATUS;
        rec_s.status      = status_val;
        rec_s.last_of_run = 1'b1;

        push.r1 = rec_s;
        if (pay_out || hdr_done) begin
            push.r0  = rec_a;
            push.cnt = in_eob ? 2'd2 : 2'd1;
        end else begin
            push.r0  = rec_s;
            push.cnt = in_eob ? 2'd1 : 2'd0;
        end
        if (!in_fire) begin
            push.cnt = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && in_eob)) begin
            phase_reg <= PH_FIRST;
            hcnt_reg  <= '0;
            fin_reg   <= 1'b0;
            op_reg    <= '0;
            mask_reg  <= 1'b0;
            len_reg   <= '0;
            key_reg   <= '0;
            kpos_reg  <= '0;
            rem_reg   <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            fin_reg   <= fin_next;
            op_reg    <= op_next;
            mask_reg  <= mask_next;
            len_reg   <= len_next;
            key_reg   <= key_next;
            kpos_reg  <= kpos_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

// ===== design/wsdfr_outq.sv =====
// Four-entry result queue: takes up to two records per cycle, gives one beat out.
// Depends on wsdfr_pkg for the record and push types.
module wsdfr_outq
    import wsdfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_rec
);

    result_t              entry_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign out_rec   = entry_mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));

    always_comb begin
        count_next = count_reg + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            entry_mem[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            entry_mem[wr_ptr_reg + Q_PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(push.cnt);
            rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/websocket_frame_deframer_core.sv =====
// WebSocket frame deframer top level: byte stream in, header, payload and status beats out.
// Depends on wsdfr_pkg, wsdfr_parser and wsdfr_outq.
//
// Takes one received byte per clock (s_tlast marks the last byte of a buffer) and parses one
// frame per buffer. Each accepted byte gives zero, one or two result beats, registered into
// the result queue: a header record when the header completes, one unmasked byte per payload
// byte, and a status beat on the buffer's last byte. Results go through a four-entry queue;
// s_tready drops while it holds three or more. The rate is one byte per cycle while m_tready
// stays high and no buffer end adds a second record. max_payload_length resets to 1024; the
// user must write it through cfg_wr_en and cfg_wr_data while the block is idle (not enforced).
module websocket_frame_deframer_core
    import wsdfr_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] in_byte
    input  logic               s_tlast,   // end_of_buffer
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] data_byte, [8] fin_flag, [12:9] frame_opcode,
                                          // [13] masked_flag, [45:14] payload_length,
                                          // [48:46] status, [55:49] zero
    output logic [1:0]         m_tuser,   // kind
    output logic               m_tlast    // last_of_run
);

    logic    run_reg;
    logic    room;
    logic    in_fire;
    push_t   push;
    result_t out_rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= 1'b1;
        end
    end

    assign s_tready = run_reg && room;
    assign in_fire  = s_tvalid && s_tready;

    wsdfr_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .in_eob      (s_tlast),
        .push        (push)
    );

    wsdfr_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec)
    );

    assign m_tdata = {7'd0, out_rec.status, out_rec.payload_length, out_rec.masked_flag,
                      out_rec.frame_opcode, out_rec.fin_flag, out_rec.data_byte};
    assign m_tuser = out_rec.kind;
    assign m_tlast = out_rec.last_of_run;

endmodule

// ===== design/wsdfr_checker.sv =====
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends on wsdfr_pkg for kind and status codes.
module wsdfr_checker
    import wsdfr_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [1:0]         m_tuser,
    input logic               m_tlast
);

    a_status_only_on_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_STATUS |-> m_tdata[48:46] == ST_OK)
        else $error("status code on a non-status beat");

    a_data_only_on_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_PAYLOAD |-> m_tdata[7:0] == 8'd0)
        else $error("data byte on a non-payload beat");

    a_status_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS |-> m_tlast)
        else $error("status beat not marked last");

    a_eob_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result queued after buffer end");

endmodule

bind websocket_frame_deframer_core wsdfr_checker u_wsdfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/testbench.sv =====
// Self-checking bench for websocket_frame_deframer_core: random and directed byte buffers,
// checked beat by beat against a cycle-free model of the frame parser.
// Depends on wsdfr_pkg and the deframer RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wsdfr_pkg::*;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [63:0] LEN_SAT = (LENGTH_BITS_DEF >= 64) ? '1
                                      : ((64'd1 << LENGTH_BITS_DEF) - 64'd1);

    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_EXT16, PH_EXT64, PH_KEY, PH_PAYLOAD, PH_DONE
    } parse_phase_e;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [31:0]        cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    websocket_frame_deframer_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // model state
    parse_phase_e pr_phase;
    logic [3:0]   pr_hdr_cnt;
    logic         pr_fin;
    logic [3:0]   pr_opcode;
    logic         pr_mask;
    logic [63:0]  pr_len;
    logic [31:0]  pr_key;
    logic [1:0]   pr_key_pos;
    logic [63:0]  pr_remaining;
    logic [31:0]  pr_max_len;

    result_t expected_beats[$];
    int      errors = 0;
    int      bytes_sent = 0;
    int      cycles = 0;
    bit      tx_idle_on = 1'b1;
    bit      rx_stall_on = 1'b1;
    int      long_hold_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void clear_frame();
        pr_phase = PH_HDR0;
        pr_hdr_cnt = '0;
        pr_fin = 1'b0;
        pr_opcode = '0;
        pr_mask = 1'b0;
        pr_len = '0;
        pr_key = '0;
        pr_key_pos = '0;
        pr_remaining = '0;
    endfunction

    function automatic result_t make_beat(logic [1:0] kind, logic [7:0] data, logic [2:0] st);
        result_t r;
        r.kind = kind;
        r.data_byte = data;
        r.fin_flag = pr_fin;
        r.frame_opcode = pr_opcode;
        r.masked_flag = pr_mask;
        r.payload_length = (pr_len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pr_len[31:0];
        r.status = st;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // length field complete; true when the header ends here (no masking key)
    function automatic bit length_done();
        pr_hdr_cnt = '0;
        if (pr_mask) begin
            pr_phase = PH_KEY;
            return 1'b0;
        end
        pr_remaining = pr_len;
        pr_phase = (pr_remaining != 0) ? PH_PAYLOAD : PH_DONE;
        return 1'b1;
    endfunction

    function automatic logic [2:0] frame_status();
        if (pr_opcode == OP_CLOSE)
            return ST_CLOSE;
        if (pr_opcode >= OP_FIRST_CTRL_RANGE && pr_opcode != OP_PONG)
            return ST_BAD_OP;
        if (!pr_mask)
            return ST_UNMASKED;
        if (!pr_fin && pr_opcode >= OP_CLOSE && pr_opcode <= OP_PONG)
            return ST_FRAG_CTRL;
        if (pr_len > {32'd0, pr_max_len})
            return ST_TOO_BIG;
        if (pr_phase != PH_DONE)
            return ST_TRUNC;
        return ST_OK;
    endfunction

    function automatic void deframe_byte(logic [7:0] b, logic eob);
        result_t beats[$];
        bit      hdr_done;
        int      sh;
        hdr_done = 1'b0;
        case (pr_phase)
            PH_HDR0: begin
                pr_fin = b[7];
                pr_opcode = b[3:0];
                pr_phase = PH_HDR1;
            end
            PH_HDR1: begin
                pr_mask = b[7];
                pr_len = {57'd0, b[6:0]};
                pr_hdr_cnt = '0;
                pr_remaining = '0;
                if (b[6:0] == 7'd126)
                    pr_phase = PH_EXT16;
                else if (b[6:0] == 7'd127)
                    pr_phase = PH_EXT64;
                else
                    hdr_done = length_done();
            end
            PH_EXT16, PH_EXT64: begin
                if (pr_remaining > (LEN_SAT >> 8))
                    pr_remaining = LEN_SAT;
                else
                    pr_remaining = {pr_remaining[55:0], b};
                pr_hdr_cnt = pr_hdr_cnt + 4'd1;
                if (pr_hdr_cnt >= ((pr_phase == PH_EXT16) ? 4'd2 : 4'd8)) begin
                    pr_len = pr_remaining;
                    hdr_done = length_done();
                end
            end
            PH_KEY: begin
                pr_key = {pr_key[23:0], b};
                pr_hdr_cnt = pr_hdr_cnt + 4'd1;
                if (pr_hdr_cnt >= 4'd4) begin
                    pr_hdr_cnt = '0;
                    pr_key_pos = '0;
                    pr_remaining = pr_len;
                    pr_phase = (pr_remaining != 0) ? PH_PAYLOAD : PH_DONE;
                    hdr_done = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                sh = 24 - 8 * pr_key_pos;
                beats.push_back(make_beat(KIND_PAYLOAD, b ^ pr_key[sh +: 8], ST_OK));
                pr_key_pos = pr_key_pos + 2'd1;
                pr_remaining = pr_remaining - 64'd1;
                if (pr_remaining == 0)
                    pr_phase = PH_DONE;
            end
            default: ;
        endcase
        if (hdr_done)
            beats.push_back(make_beat(KIND_HEADER, 8'd0, ST_OK));
        if (eob) begin
            beats.push_back(make_beat(KIND_STATUS, 8'd0, frame_status()));
            clear_frame();
        end
        if (beats.size() > 0)
            beats[beats.size() - 1].last_of_run = 1'b1;
        foreach (beats[i])
            expected_beats.push_back(beats[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.data_byte = m_tdata[7:0];
            got.fin_flag = m_tdata[8];
            got.frame_opcode = m_tdata[12:9];
            got.masked_flag = m_tdata[13];
            got.payload_length = m_tdata[45:14];
            got.status = m_tdata[48:46];
            got.last_of_run = m_tlast;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("data_byte", want.data_byte, got.data_byte);
                check_field("fin_flag", want.fin_flag, got.fin_flag);
                check_field("frame_opcode", want.frame_opcode, got.frame_opcode);
                check_field("masked_flag", want.masked_flag, got.masked_flag);
                check_field("payload_length", want.payload_length, got.payload_length);
                check_field("status", want.status, got.status);
                check_field("last_of_run", want.last_of_run, got.last_of_run);
            end
        end
    end

    // result sink: random stalls, plus a long hold on request
    initial begin
        int hold_left;
        forever begin
            @(posedge aclk);
            if (long_hold_cycles != 0) begin
                m_tready <= 1'b0;
                hold_left = long_hold_cycles;
                long_hold_cycles = 0;
                while (hold_left > 0) begin
                    @(posedge aclk);
                    hold_left--;
                end
            end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (idle_len()) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eob;
        do @(posedge aclk); while (!s_tready);
        deframe_byte(b, eob);
        bytes_sent++;
        gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_buffer(input logic [7:0] buf_bytes[$]);
        foreach (buf_bytes[i])
            send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_max_len(input logic [31:0] v);
        wait_for_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        pr_max_len = v;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_frame();
        logic [7:0]  fb[$];
        logic [3:0]  op;
        logic        fin, mk;
        logic [63:0] len;
        int          r, form, n_pay, cut;
        r = $urandom_range(0, 9);
        if (r < 6)
            op = 4'($urandom_range(0, 2));
        else if (r < 8)
            op = OP_CLOSE + 4'($urandom_range(0, 2));
        else
            op = 4'($urandom_range(3, 15));
        fin = ($urandom_range(0, 4) != 0);
        mk = ($urandom_range(0, 7) != 0);
        r = $urandom_range(0, 9);
        form = (r < 7) ? 0 : (r < 9) ? 1 : 2;
        case (form)
            0: len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
            1: len = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
            default: begin
                r = $urandom_range(0, 3);
                if (r == 0)
                    len = $urandom_range(0, 30);
                else if (r == 1)
                    len = {32'd0, 32'($urandom)};
                else if (r == 2)
                    len = {32'($urandom), 32'($urandom)};
                else
                    len = '1;
            end
        endcase
        fb.push_back({fin, 3'($urandom_range(0, 7)), op});
        if (form == 0) begin
            fb.push_back({mk, len[6:0]});
        end else if (form == 1) begin
            fb.push_back({mk, 7'd126});
            fb.push_back(len[15:8]);
            fb.push_back(len[7:0]);
        end else begin
            fb.push_back({mk, 7'd127});
            for (int i = 7; i >= 0; i--)
                fb.push_back(len[8*i +: 8]);
        end
        if (mk)
            repeat (4) fb.push_back(8'($urandom_range(0, 255)));
        n_pay = (len <= 64'd40) ? int'(len) : $urandom_range(0, 20);
        if ($urandom_range(0, 7) == 0)
            n_pay = $urandom_range(0, n_pay);
        repeat (n_pay) fb.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) fb.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, fb.size());
            while (fb.size() > cut) void'(fb.pop_back());
        end
        send_buffer(fb);
    endtask

    task automatic send_noise_buffer();
        logic [7:0] fb[$];
        repeat ($urandom_range(1, 8)) fb.push_back(8'($urandom_range(0, 255)));
        send_buffer(fb);
    endtask

    task automatic test_status_cases();
        tx_idle_on = 1'b1;
        rx_stall_on = 1'b1;
        send_buffer('{8'h88});
        send_buffer('{8'h89, 8'h80});
        send_buffer('{8'h01, 8'h00});
        send_buffer('{8'h0A, 8'h80, 8'h11, 8'h22, 8'h33, 8'h44});
        send_buffer('{8'h82, 8'hFE, 8'h04, 8'h01});
        send_buffer('{8'h82, 8'hFF});
        send_buffer('{8'h81, 8'h83, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h12, 8'h34, 8'hFF, 8'h00});
        send_buffer('{8'h81, 8'h02, 8'hFF, 8'h00});
        wait_for_results();
    endtask

    task automatic test_backpressure();
        logic [7:0] fb[$];
        tx_idle_on = 1'b0;
        rx_stall_on = 1'b0;
        long_hold_cycles = 300;
        fb = '{8'h82, 8'h94, 8'h5A, 8'hC3, 8'h0F, 8'hF0};
        repeat (20) fb.push_back(8'($urandom_range(0, 255)));
        send_buffer(fb);
        repeat (6) send_random_frame();
        wait_for_results();
        tx_idle_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    task automatic test_length_limits();
        logic [31:0] limits[$];
        logic [7:0]  sat_frame[$];
        limits = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd126, 32'($urandom), MAX_LEN_RESET};
        sat_frame = '{8'h82, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h01, 8'h02, 8'h03, 8'h04, 8'hEE};
        foreach (limits[i]) begin
            set_max_len(limits[i]);
            send_buffer(sat_frame);
            repeat (4) send_random_frame();
        end
        wait_for_results();
    endtask

    task automatic test_random_frames();
        int target;
        target = bytes_sent + 500;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 15) == 0) begin
                tx_idle_on = $urandom_range(0, 1);
                rx_stall_on = $urandom_range(0, 1);
            end
            if ($urandom_range(0, 99) < 85)
                send_random_frame();
            else
                send_noise_buffer();
        end
        wait_for_results();
    endtask

    initial begin
        pr_max_len = MAX_LEN_RESET;
        clear_frame();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_status_cases();
        test_backpressure();
        test_length_limits();
        test_random_frames();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
